[design/gba_pkg.sv]
`default_nettype none

package gba_pkg;

  // field widths
  localparam int KIND_W      = 2;
  localparam int UNIT_NUM_W  = 14;
  localparam int UNITS_W     = 11;
  localparam int GROUPS_W    = 4;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int BYTE_W      = 8;
  localparam int BIT_SEL_W   = 3;
  localparam int BYTE_SEL_W  = UNITS_W - BIT_SEL_W;

  // divider: one quotient bit per step
  localparam int DIV_STEPS   = UNIT_NUM_W;
  localparam int DIV_STEP_W  = $clog2(DIV_STEPS);

  localparam logic [UNITS_W-1:0] COUNT_MAX = '1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK    = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[design/gba_div.sv]
`default_nettype none

// restoring divider, one quotient bit per cycle
module gba_div (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire  [gba_pkg::UNIT_NUM_W-1:0]   dividend,
  input  wire  [gba_pkg::UNITS_W-1:0]      divisor,
  output gba_pkg::div_stat_t               stat,
  output logic [gba_pkg::UNIT_NUM_W-1:0]   quotient,
  output logic [gba_pkg::UNITS_W-1:0]      remainder
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [gba_pkg::DIV_STEP_W-1:0]    step_r, step_nxt;
  logic [gba_pkg::UNIT_NUM_W-1:0]    quo_r, quo_nxt;
  logic [gba_pkg::UNITS_W-1:0]       rem_r, rem_nxt;
  logic [gba_pkg::UNITS_W-1:0]       dsr_r, dsr_nxt;
  logic [gba_pkg::UNITS_W:0]         shifted;
  logic [gba_pkg::UNITS_W:0]         diff;
  logic                              ge;

  assign shifted = {rem_r, quo_r[gba_pkg::UNIT_NUM_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign ge      = shifted >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[gba_pkg::UNIT_NUM_W-2:0], ge};
      rem_nxt  = ge ? diff[gba_pkg::UNITS_W-1:0] : shifted[gba_pkg::UNITS_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == gba_pkg::DIV_STEP_W'(gba_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[design/gba_store.sv]
`default_nettype none

// bitmap bytes and group counts, cleared by a sweep after reset
module gba_store #(
  parameter  int MAX_GROUPS   = 8,
  parameter  int BITMAP_BYTES = 128,
  localparam int DEPTH        = MAX_GROUPS * BITMAP_BYTES,
  localparam int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int GW           = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
  input  wire                            clk,
  input  wire                            rst_n,
  output logic                           busy,
  input  wire                            bm_we,
  input  wire  [AW-1:0]                  bm_addr,
  input  wire  [gba_pkg::BYTE_W-1:0]     bm_wdata,
  output logic [gba_pkg::BYTE_W-1:0]     bm_rdata,
  input  wire                            cnt_we,
  input  wire  [GW-1:0]                  cnt_addr,
  input  wire  [gba_pkg::UNITS_W-1:0]    cnt_wdata,
  output logic [gba_pkg::UNITS_W-1:0]    cnt_rdata
);

  logic [gba_pkg::BYTE_W-1:0]  bm_mem  [DEPTH];
  logic [gba_pkg::UNITS_W-1:0] cnt_mem [MAX_GROUPS];

  logic                        clr_r, clr_nxt;
  logic [AW-1:0]               clr_addr_r, clr_addr_nxt;
  logic                        bm_wen;
  logic [AW-1:0]               bm_waddr;
  logic [gba_pkg::BYTE_W-1:0]  bm_wd;
  logic                        cnt_wen;
  logic [GW-1:0]               cnt_waddr;
  logic [gba_pkg::UNITS_W-1:0] cnt_wd;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // sweep takes over the write ports while it runs
  assign bm_wen    = clr_r | bm_we;
  assign bm_waddr  = clr_r ? clr_addr_r : bm_addr;
  assign bm_wd     = clr_r ? '0 : bm_wdata;
  assign cnt_wen   = clr_r ? (32'(clr_addr_r) < MAX_GROUPS) : cnt_we;
  assign cnt_waddr = clr_r ? clr_addr_r[GW-1:0] : cnt_addr;
  assign cnt_wd    = clr_r ? '0 : cnt_wdata;

  always_ff @(posedge clk) begin
    if (bm_wen) begin
      bm_mem[bm_waddr] <= bm_wd;
    end
    bm_rdata <= bm_mem[bm_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_wen) begin
      cnt_mem[cnt_waddr] <= cnt_wd;
    end
    cnt_rdata <= cnt_mem[cnt_addr];
  end

  assign busy = clr_r;

endmodule

`default_nettype wire

[design/grouped_bitmap_allocator.sv]
`default_nettype none

// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_kind, in_unit_number
// out      output     out_valid / out_ready out_granted, out_status
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// allocate: reads group counts until a present group has room, then scans
//   that group's bitmap bytes; each count and byte goes through one
//   synchronous memory read
// release / mark: the 14-step divider splits the unit number into group and
//   bit, then a read-modify-write of byte and count
// reset: a sweep over all MAX_GROUPS*BITMAP_BYTES bytes clears the bitmap and the
//   counts, in_ready stays low meanwhile; config writes are taken as ever
// a result sits in the output register while the next item is accepted; a
//   second result waits in the done state until the output register frees
module grouped_bitmap_allocator #(
  parameter int MAX_GROUPS   = 8,
  parameter int BITMAP_BYTES = 128
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [gba_pkg::KIND_W-1:0]       in_kind,
  input  wire  [gba_pkg::UNIT_NUM_W-1:0]   in_unit_number,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [gba_pkg::UNIT_NUM_W-1:0]   out_granted,
  output logic [gba_pkg::STATUS_W-1:0]     out_status,
  input  wire                              cfg_we,
  input  wire  [gba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [gba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DEPTH    = MAX_GROUPS * BITMAP_BYTES;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GW       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW       = $clog2(MAX_GROUPS + 1);
  localparam int TW       = CW + gba_pkg::UNITS_W;
  localparam int UNIT_CAP = BITMAP_BYTES * gba_pkg::BYTE_W;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_GRD  = 4'd2;   // issue group count read
  localparam logic [3:0] S_GCHK = 4'd3;   // test group count
  localparam logic [3:0] S_BRD  = 4'd4;   // issue bitmap byte read
  localparam logic [3:0] S_BCHK = 4'd5;   // look for a clear bit
  localparam logic [3:0] S_RCHK = 4'd6;   // range check for release / mark
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_RRD  = 4'd8;
  localparam logic [3:0] S_RMOD = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]                        state_r, state_nxt;
  logic [gba_pkg::UNITS_W-1:0]       cfg_units_r;
  logic [gba_pkg::GROUPS_W-1:0]      cfg_groups_r;

  logic [gba_pkg::KIND_W-1:0]        kind_r, kind_nxt;
  logic [gba_pkg::UNIT_NUM_W-1:0]    num_r, num_nxt;
  logic [gba_pkg::UNITS_W-1:0]       units_r, units_nxt;
  logic [CW-1:0]                     groups_r, groups_nxt;
  logic [TW-1:0]                     total_r, total_nxt;
  logic [CW-1:0]                     g_r, g_nxt;
  logic [gba_pkg::BYTE_SEL_W-1:0]    n_r, n_nxt;
  logic [gba_pkg::BIT_SEL_W-1:0]     bsel_r, bsel_nxt;
  logic [gba_pkg::UNITS_W-1:0]       cnt_val_r, cnt_val_nxt;
  logic [TW-1:0]                     base_r, base_nxt;
  logic [gba_pkg::UNIT_NUM_W-1:0]    res_granted_r, res_granted_nxt;
  logic [gba_pkg::STATUS_W-1:0]      res_status_r, res_status_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [gba_pkg::UNIT_NUM_W-1:0]    out_granted_r, out_granted_nxt;
  logic [gba_pkg::STATUS_W-1:0]      out_status_r, out_status_nxt;

  logic [gba_pkg::UNITS_W-1:0]       eff_units;
  logic [CW-1:0]                     eff_groups;
  logic [gba_pkg::UNIT_NUM_W-1:0]    idx;

  // store ports
  logic                              store_busy;
  logic                              bm_we;
  logic [AW-1:0]                     bm_addr;
  logic [gba_pkg::BYTE_W-1:0]        bm_wdata;
  logic [gba_pkg::BYTE_W-1:0]        bm_rdata;
  logic                              cnt_we;
  logic [GW-1:0]                     cnt_addr;
  logic [gba_pkg::UNITS_W-1:0]       cnt_wdata;
  logic [gba_pkg::UNITS_W-1:0]       cnt_rdata;

  // divider
  logic                              div_start;
  gba_pkg::div_stat_t                div_stat;
  logic [gba_pkg::UNIT_NUM_W-1:0]    div_quo;
  logic [gba_pkg::UNITS_W-1:0]       div_rem;

  // byte scan
  logic                              hit;
  logic [gba_pkg::BIT_SEL_W-1:0]     hit_pos;
  logic [gba_pkg::UNITS_W:0]         next_start;
  logic [gba_pkg::BYTE_W-1:0]        bit_mask;
  logic                              bit_set;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_units_r  <= gba_pkg::UNITS_W'(1024);
      cfg_groups_r <= gba_pkg::GROUPS_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        gba_pkg::CFG_UNITS:  cfg_units_r  <= cfg_wdata[gba_pkg::UNITS_W-1:0];
        gba_pkg::CFG_GROUPS: cfg_groups_r <= cfg_wdata[gba_pkg::GROUPS_W-1:0];
        default: ;
      endcase
    end
  end

  // oversized settings clip to what the store holds
  assign eff_units  = (32'(cfg_units_r) > UNIT_CAP) ? gba_pkg::UNITS_W'(UNIT_CAP)
                                                    : cfg_units_r;
  assign eff_groups = (32'(cfg_groups_r) > MAX_GROUPS) ? CW'(MAX_GROUPS)
                                                       : CW'(cfg_groups_r);

  assign idx = num_r - 1'b1;

  // first clear bit of the byte, msb first, limited to units of the group
  always_comb begin
    logic [gba_pkg::UNITS_W-1:0] unit_pos;
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = gba_pkg::BYTE_W - 1; j >= 0; j--) begin
      unit_pos = {n_r, gba_pkg::BIT_SEL_W'(j)};
      if (unit_pos < units_r && !bm_rdata[gba_pkg::BYTE_W-1-j]) begin
        hit     = 1'b1;
        hit_pos = gba_pkg::BIT_SEL_W'(j);
      end
    end
  end

  assign next_start = {1'b0, n_r + 1'b1, {gba_pkg::BIT_SEL_W{1'b0}}};
  assign bit_mask   = gba_pkg::BYTE_W'(8'h80) >> bsel_r;
  assign bit_set    = (bm_rdata & bit_mask) != '0;

  assign bm_addr  = AW'(g_r[GW-1:0]) * AW'(BITMAP_BYTES) + AW'(n_r);
  assign cnt_addr = g_r[GW-1:0];

  assign in_ready = (state_r == S_IDLE) && !store_busy;

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    num_nxt         = num_r;
    units_nxt       = units_r;
    groups_nxt      = groups_r;
    total_nxt       = total_r;
    g_nxt           = g_r;
    n_nxt           = n_r;
    bsel_nxt        = bsel_r;
    cnt_val_nxt     = cnt_val_r;
    base_nxt        = base_r;
    res_granted_nxt = res_granted_r;
    res_status_nxt  = res_status_r;
    bm_we           = 1'b0;
    bm_wdata        = bm_rdata;
    cnt_we          = 1'b0;
    cnt_wdata       = cnt_rdata;
    div_start       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          kind_nxt  = in_kind;
          num_nxt   = in_unit_number;
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        units_nxt       = eff_units;
        groups_nxt      = eff_groups;
        total_nxt       = TW'(eff_groups) * TW'(eff_units);
        g_nxt           = '0;
        res_granted_nxt = '0;
        res_status_nxt  = gba_pkg::ST_DONE;
        unique case (kind_r) inside
          gba_pkg::KIND_ALLOC:                    state_nxt = S_GRD;
          gba_pkg::KIND_RELEASE, gba_pkg::KIND_MARK: state_nxt = S_RCHK;
          default:                                state_nxt = S_DONE;
        endcase
      end

      S_GRD: begin
        if (g_r == groups_r) begin
          res_status_nxt = gba_pkg::ST_NO_FREE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_GCHK;
        end
      end

      S_GCHK: begin
        if (cnt_rdata < units_r) begin
          cnt_val_nxt = cnt_rdata;
          base_nxt    = TW'(g_r) * TW'(units_r);
          n_nxt       = '0;
          state_nxt   = S_BRD;
        end else begin
          g_nxt     = g_r + 1'b1;
          state_nxt = S_GRD;
        end
      end

      S_BRD: state_nxt = S_BCHK;

      S_BCHK: begin
        if (hit) begin
          bm_we           = 1'b1;
          bm_wdata        = bm_rdata | (gba_pkg::BYTE_W'(8'h80) >> hit_pos);
          cnt_we          = 1'b1;
          cnt_wdata       = cnt_val_r + 1'b1;
          res_granted_nxt = gba_pkg::UNIT_NUM_W'(base_r + TW'({n_r, hit_pos}) + TW'(1));
          state_nxt       = S_DONE;
        end else if (next_start >= {1'b0, units_r}) begin
          // the group's count said free but its bitmap has no clear bit
          res_status_nxt = gba_pkg::ST_NO_FREE;
          state_nxt      = S_DONE;
        end else begin
          n_nxt     = n_r + 1'b1;
          state_nxt = S_BRD;
        end
      end

      S_RCHK: begin
        if (num_r == '0 || 32'(idx) >= 32'(total_r)) begin
          res_status_nxt = gba_pkg::ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (div_stat.done) begin
          g_nxt     = CW'(div_quo);
          n_nxt     = div_rem[gba_pkg::UNITS_W-1:gba_pkg::BIT_SEL_W];
          bsel_nxt  = div_rem[gba_pkg::BIT_SEL_W-1:0];
          state_nxt = S_RRD;
        end
      end

      S_RRD: state_nxt = S_RMOD;

      S_RMOD: begin
        // count moves only with the bit and saturates at both ends
        if (kind_r == gba_pkg::KIND_RELEASE && bit_set) begin
          bm_we     = 1'b1;
          bm_wdata  = bm_rdata & ~bit_mask;
          cnt_we    = 1'b1;
          cnt_wdata = (cnt_rdata != '0) ? cnt_rdata - 1'b1 : cnt_rdata;
        end else if (kind_r == gba_pkg::KIND_MARK && !bit_set) begin
          bm_we     = 1'b1;
          bm_wdata  = bm_rdata | bit_mask;
          cnt_we    = 1'b1;
          cnt_wdata = (cnt_rdata != gba_pkg::COUNT_MAX) ? cnt_rdata + 1'b1 : cnt_rdata;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = res_granted_r;
      out_status_nxt  = res_status_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    num_r         <= num_nxt;
    units_r       <= units_nxt;
    groups_r      <= groups_nxt;
    total_r       <= total_nxt;
    g_r           <= g_nxt;
    n_r           <= n_nxt;
    bsel_r        <= bsel_nxt;
    cnt_val_r     <= cnt_val_nxt;
    base_r        <= base_nxt;
    res_granted_r <= res_granted_nxt;
    res_status_r  <= res_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_status  = out_status_r;

  gba_store #(
    .MAX_GROUPS   (MAX_GROUPS),
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (store_busy),
    .bm_we     (bm_we),
    .bm_addr   (bm_addr),
    .bm_wdata  (bm_wdata),
    .bm_rdata  (bm_rdata),
    .cnt_we    (cnt_we),
    .cnt_addr  (cnt_addr),
    .cnt_wdata (cnt_wdata),
    .cnt_rdata (cnt_rdata)
  );

  gba_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (idx),
    .divisor   (units_r),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

`ifndef SYNTH
  // divider results only land while the sequencer waits for them
  assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  // an allocation never bumps a group that was already full
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_we && state_r == S_BCHK) |-> cnt_val_r < units_r)
    else $error("allocation on a full group");

  // a new result only appears from the done state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside the done state");
`endif

endmodule

`default_nettype wire

[tb/grouped_bitmap_allocator_tb.sv]
`timescale 1ns / 100ps

module grouped_bitmap_allocator_tb;

  // block sizing, kept at the block's defaults
  localparam int N_GROUPS     = 8;
  localparam int BITMAP_BYTES = 128;
  localparam int UNIT_CAP     = BITMAP_BYTES * gba_pkg::BYTE_W;

  // the one kind the block must ignore
  localparam logic [gba_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  // stimulus shaping
  localparam int FILL_CHUNK   = 40;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_SPACING = 350;
  // longest allocate is a full count search and a full bitmap scan; this covers a late result
  localparam int DRAIN_CYCLES = 400;
  // covers the reset sweep, a long hold with a full block and a full bitmap scan
  localparam int IDLE_LIMIT   = 20000;

  typedef struct packed {
    logic [gba_pkg::KIND_W-1:0]     kind;
    logic [gba_pkg::UNIT_NUM_W-1:0] num;
  } alloc_req_t;

  typedef struct packed {
    logic [gba_pkg::UNIT_NUM_W-1:0] granted;
    logic [gba_pkg::STATUS_W-1:0]   status;
  } grant_t;

  logic                           clk;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  logic [gba_pkg::KIND_W-1:0]     in_kind        = gba_pkg::KIND_ALLOC;
  logic [gba_pkg::UNIT_NUM_W-1:0] in_unit_number = '0;
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  logic [gba_pkg::UNIT_NUM_W-1:0] out_granted;
  logic [gba_pkg::STATUS_W-1:0]   out_status;
  logic                           cfg_we         = 1'b0;
  logic [gba_pkg::CFG_IDX_W-1:0]  cfg_index      = gba_pkg::CFG_UNITS;
  logic [gba_pkg::CFG_DATA_W-1:0] cfg_wdata      = '0;

  // items waiting for the driver, results waiting for the monitor
  alloc_req_t req_queue [$];
  grant_t     grants_due [$];

  // shadow of the allocator: used bits, per-group used counts, layout registers
  bit                           used_map [N_GROUPS][UNIT_CAP];
  bit [gba_pkg::UNITS_W-1:0]    used_cnt [N_GROUPS];
  logic [gba_pkg::UNITS_W-1:0]  layout_units  = 11'd1024;
  logic [gba_pkg::GROUPS_W-1:0] layout_groups = 4'd8;

  // driver pacing
  alloc_req_t head_req;
  int         burst_left = 0;
  int         gap_left   = 0;

  // monitor and receiver state
  grant_t due_head;
  int     mismatches   = 0;
  int     results_seen = 0;
  int     next_hold_at = 200;
  int     stall_left   = 0;
  int     calm_left    = 0;
  int     idle_cycles  = 0;

  grouped_bitmap_allocator #(
    .MAX_GROUPS  (N_GROUPS),
    .BITMAP_BYTES(BITMAP_BYTES)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_unit_number(in_unit_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_granted   (out_granted),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // oversized registers are clamped to what the store holds
  function automatic int eff_units();
    return (layout_units > UNIT_CAP) ? UNIT_CAP : int'(layout_units);
  endfunction

  function automatic int eff_groups();
    return (layout_groups > N_GROUPS) ? N_GROUPS : int'(layout_groups);
  endfunction

  // advance the shadow by one accepted item and queue the result it must give
  function automatic void apply_request(input alloc_req_t r);
    int     units;
    int     groups;
    int     g;
    int     b;
    int     idx;
    grant_t res;
    units       = eff_units();
    groups      = eff_groups();
    res.granted = '0;
    res.status  = gba_pkg::ST_DONE;
    if (r.kind == gba_pkg::KIND_ALLOC) begin
      res.status = gba_pkg::ST_NO_FREE;
      // first present group whose count says it has room
      g = 0;
      while (g < groups && used_cnt[g] >= units) g++;
      // only that group is scanned, first clear bit wins
      if (g < groups) begin
        for (b = 0; b < units && res.status != gba_pkg::ST_DONE; b++) begin
          if (!used_map[g][b]) begin
            used_map[g][b] = 1'b1;
            used_cnt[g]++;
            res.granted = gba_pkg::UNIT_NUM_W'(g * units + b + 1);
            res.status  = gba_pkg::ST_DONE;
          end
        end
      end
    end else if (r.kind == gba_pkg::KIND_RELEASE || r.kind == gba_pkg::KIND_MARK) begin
      if (r.num == 0 || r.num > groups * units) begin
        res.status = gba_pkg::ST_RANGE;
      end else begin
        idx = r.num - 1;
        g   = idx / units;
        b   = idx % units;
        // count moves only when the bit flips, and never wraps
        if (r.kind == gba_pkg::KIND_RELEASE && used_map[g][b]) begin
          used_map[g][b] = 1'b0;
          if (used_cnt[g] != 0) used_cnt[g]--;
        end else if (r.kind == gba_pkg::KIND_MARK && !used_map[g][b]) begin
          used_map[g][b] = 1'b1;
          if (used_cnt[g] != gba_pkg::COUNT_MAX) used_cnt[g]++;
        end
      end
    end
    grants_due.push_back(res);
  endfunction

  // a unit that is in use now, so most releases free something real
  function automatic int find_used_unit(input int units, input int groups);
    int total;
    int start;
    int k;
    int n;
    total = units * groups;
    if (total == 0) return 0;
    start = $urandom_range(0, total - 1);
    for (k = 0; k < total; k++) begin
      n = (start + k) % total;
      if (used_map[n / units][n % units]) return n + 1;
    end
    return $urandom_range(1, total);
  endfunction

  // mostly well-formed traffic against the current map, some noise
  function automatic alloc_req_t random_req();
    int         units;
    int         groups;
    int         total;
    int         pick;
    alloc_req_t r;
    units  = eff_units();
    groups = eff_groups();
    total  = units * groups;
    pick   = $urandom_range(0, 15);
    r.kind = gba_pkg::KIND_ALLOC;
    r.num  = gba_pkg::UNIT_NUM_W'($urandom_range(0, 16383));
    if (pick < 7) begin
      r.kind = gba_pkg::KIND_ALLOC;
    end else if (pick < 11) begin
      r.kind = gba_pkg::KIND_RELEASE;
      r.num  = gba_pkg::UNIT_NUM_W'(find_used_unit(units, groups));
    end else if (pick < 13) begin
      r.kind = gba_pkg::KIND_MARK;
      r.num  = (total > 0) ? gba_pkg::UNIT_NUM_W'($urandom_range(1, total)) : '0;
    end else if (pick < 14) begin
      // may hit a free unit, a redundant release
      r.kind = gba_pkg::KIND_RELEASE;
      r.num  = (total > 0) ? gba_pkg::UNIT_NUM_W'($urandom_range(1, total)) : '0;
    end else begin
      // any kind, any number, out of range included
      r.kind = gba_pkg::KIND_W'($urandom_range(0, 3));
    end
    return r;
  endfunction

  function automatic void queue_req(input logic [gba_pkg::KIND_W-1:0] kind, input int num);
    alloc_req_t r;
    r.kind = kind;
    r.num  = gba_pkg::UNIT_NUM_W'(num);
    req_queue.push_back(r);
  endfunction

  // refill in chunks so each chunk sees the map as it stands
  task automatic queue_random(input int n);
    int left;
    int k;
    left = n;
    while (left > 0) begin
      while (req_queue.size() != 0) @(negedge clk);
      for (k = 0; k < FILL_CHUNK && left > 0; k++) begin
        req_queue.push_back(random_req());
        left--;
      end
    end
  endtask

  // sender pauses until everything sent has come back
  task automatic wait_drained();
    while (req_queue.size() != 0 || in_valid || grants_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_layout(input int units, input int groups);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= gba_pkg::CFG_UNITS;
    cfg_wdata <= gba_pkg::CFG_DATA_W'(units);
    @(posedge clk);
    cfg_index <= gba_pkg::CFG_GROUPS;
    cfg_wdata <= gba_pkg::CFG_DATA_W'(groups);
    @(posedge clk);
    cfg_we        <= 1'b0;
    layout_units  = gba_pkg::UNITS_W'(units);
    layout_groups = gba_pkg::GROUPS_W'(groups);
  endtask

  // driver: bursts of items with random gaps, payload held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        head_req.kind = in_kind;
        head_req.num  = in_unit_number;
        apply_request(head_req);
      end
      if (!in_valid || in_ready) begin
        if (burst_left > 0 && req_queue.size() > 0) begin
          head_req = req_queue.pop_front();
          in_valid       <= 1'b1;
          in_kind        <= head_req.kind;
          in_unit_number <= head_req.num;
          burst_left--;
        end else begin
          in_valid <= 1'b0;
          if (burst_left == 0) begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              burst_left = $urandom_range(1, 40);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
          end
        end
      end
    end
  end

  // monitor: check each result against the oldest one due, and pace out_ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          $display("%0t: result with nothing due, granted %0d status %0d",
                   $time, out_granted, out_status);
          mismatches++;
        end else begin
          due_head = grants_due.pop_front();
          if (out_granted !== due_head.granted) begin
            $display("%0t: granted expected %0d actual %0d",
                     $time, due_head.granted, out_granted);
            mismatches++;
          end
          if (out_status !== due_head.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, due_head.status, out_status);
            mismatches++;
          end
        end
        results_seen++;
        // long hold while the sender still has plenty to offer, so the block backs up
        if (results_seen >= next_hold_at && req_queue.size() >= FILL_CHUNK / 2) begin
          stall_left   = LONG_HOLD;
          next_hold_at = results_seen + HOLD_SPACING;
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        out_ready <= 1'b1;
        calm_left--;
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(10, 60);
        else if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  // watchdog: too long with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("grouped_bitmap_allocator_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset layout: 1024 units in 8 groups
    queue_req(gba_pkg::KIND_ALLOC, 0);
    queue_req(gba_pkg::KIND_ALLOC, 16383);       // number ignored by allocate
    queue_req(gba_pkg::KIND_RELEASE, 1);
    queue_req(gba_pkg::KIND_ALLOC, 0);           // refills the hole at unit 1
    queue_req(gba_pkg::KIND_RELEASE, 0);         // zero is out of range
    queue_req(gba_pkg::KIND_MARK, 8192);         // last unit of the last group
    queue_req(gba_pkg::KIND_MARK, 8192);         // redundant mark
    queue_req(gba_pkg::KIND_RELEASE, 8192);
    queue_req(gba_pkg::KIND_RELEASE, 8192);      // redundant release
    queue_req(gba_pkg::KIND_MARK, 8193);         // one past the end
    queue_req(gba_pkg::KIND_RELEASE, 16383);
    queue_req(KIND_UNUSED, 16383);
    queue_req(gba_pkg::KIND_MARK, 1);            // already used
    wait_drained();

    // one group of one byte: allocate seven of its eight units, mark past the end, release and refill
    set_layout(8, 1);
    repeat (7) queue_req(gba_pkg::KIND_ALLOC, 0);
    queue_req(gba_pkg::KIND_MARK, 9);
    queue_req(gba_pkg::KIND_RELEASE, 5);
    queue_req(gba_pkg::KIND_ALLOC, 0);
    wait_drained();

    // no group present
    set_layout(16, 0);
    queue_req(gba_pkg::KIND_ALLOC, 0);
    queue_req(gba_pkg::KIND_RELEASE, 1);
    wait_drained();

    // both registers above what the store holds
    set_layout(2047, 15);
    queue_req(gba_pkg::KIND_MARK, 8192);
    queue_req(gba_pkg::KIND_MARK, 8193);
    wait_drained();

    // random traffic over a spread of layouts
    set_layout(8, 3);
    queue_random(140);
    wait_drained();
    set_layout(1024, 8);
    queue_random(140);
    wait_drained();
    set_layout(100, 2);
    queue_random(140);
    wait_drained();
    set_layout(2047, 15);
    queue_random(100);
    wait_drained();
    set_layout(0, 5);                   // no unit in any group
    queue_random(20);
    wait_drained();
    set_layout(16, 8);
    queue_random(140);
    wait_drained();
    repeat (2) begin
      set_layout($urandom_range(8, 1024), $urandom_range(1, 8));
      queue_random(120);
      wait_drained();
    end

    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("grouped_bitmap_allocator_tb OK");
    else $display("grouped_bitmap_allocator_tb NOT OK");
    $finish;
  end

endmodule
